// ===== src/terfr_pkg.sv =====
`default_nettype none
package terfr_pkg;

	localparam int TILE_SIZE = 64;
	localparam int COORD_W = 6;
	localparam int DELTA_W = COORD_W + 1;
	localparam int PROD_W = 2 * DELTA_W;
	localparam int EDGE_W = PROD_W + 1;
	localparam int COV_W = 64;
	localparam int COLOR_W = 32;
	localparam int S_FIELDS_W = 6 * COORD_W + COLOR_W;
	localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * COORD_W + COV_W + COLOR_W;
	localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W = M_TDATA_W - M_FIELDS_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DELTA_W-1:0] delta_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [EDGE_W-1:0] edge_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOX,
		ST_MUL,
		ST_SUM,
		ST_FEED,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		logic [COLOR_W-1:0] color;
	} tri_in_t;

	typedef struct packed {
		coord_t xmin;
		coord_t span_w;
		edge_t c0;
		edge_t c1;
		edge_t c2;
		logic [COLOR_W-1:0] color;
	} tri_t;

	typedef struct packed {
		logic valid;
		logic last;
		coord_t row;
		edge_t w0;
		edge_t w1;
		edge_t w2;
		logic [COV_W-1:0] mask;
	} link_t;

	function automatic coord_t clamp_coord(coord_t v);
		coord_t r;
		r = v;
		if ({1'b0, v} >= DELTA_W'(TILE_SIZE)) begin
			r = COORD_W'(TILE_SIZE - 1);
		end
		return r;
	endfunction

	function automatic edge_t sext_delta(delta_t d);
		return {{(EDGE_W-DELTA_W){d[DELTA_W-1]}}, d};
	endfunction

	function automatic edge_t sext_prod(prod_t p);
		return {{(EDGE_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic prod_t smul(delta_t a, delta_t b);
		logic signed [PROD_W-1:0] sa;
		logic signed [PROD_W-1:0] sb;
		sa = signed'({{(PROD_W-DELTA_W){a[DELTA_W-1]}}, a});
		sb = signed'({{(PROD_W-DELTA_W){b[DELTA_W-1]}}, b});
		return PROD_W'(sa * sb);
	endfunction

endpackage
`default_nettype wire

// ===== src/terfr_cell.sv =====
`default_nettype none
module terfr_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire terfr_pkg::coord_t idx,
	input  wire terfr_pkg::tri_t   tri_info,
	input  wire terfr_pkg::link_t  link_in,
	output terfr_pkg::link_t       link_out
);
	import terfr_pkg::*;

	logic valid_q;
	logic last_q;
	coord_t row_q;
	edge_t w0_q;
	edge_t w1_q;
	edge_t w2_q;
	logic [COV_W-1:0] mask_q;
	logic hit;

	// pixel inside when the edge values w0, w1 and w2 are all non-negative and column in the box
	assign hit = !link_in.w0[EDGE_W-1] && !link_in.w1[EDGE_W-1] && !link_in.w2[EDGE_W-1]
		&& (idx <= tri_info.span_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= link_in.last;
			row_q <= link_in.row;
			w0_q <= link_in.w0;
			w1_q <= link_in.w1;
			w2_q <= link_in.w2;
			mask_q <= link_in.mask | (hit ? (COV_W'(1) << idx) : COV_W'(0));
		end
	end

	assign link_out.valid = valid_q;
	assign link_out.last = last_q;
	assign link_out.row = row_q;
	assign link_out.w0 = w0_q + tri_info.c0;
	assign link_out.w1 = w1_q + tri_info.c1;
	assign link_out.w2 = w2_q + tri_info.c2;
	assign link_out.mask = mask_q;

	a_mask_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((mask_q >> idx) < COV_W'(2)))
		else $error("coverage bit set beyond this cell");

endmodule
`default_nettype wire

// ===== src/terfr_setup.sv =====
`default_nettype none
module terfr_setup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire terfr_pkg::tri_in_t tri_in,
	input  wire logic               en,
	input  wire logic               done,
	output terfr_pkg::link_t        head,
	output terfr_pkg::tri_t         tri_info
);
	import terfr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic accept;
	logic feed;

	coord_t vx_q [3];
	coord_t vy_q [3];
	logic [COLOR_W-1:0] color_q;
	coord_t xmin_q;
	coord_t xmax_q;
	coord_t ymin_q;
	coord_t ymax_q;
	coord_t yrow_q;
	delta_t c_q [3];
	delta_t r_q [3];
	prod_t pa_q [3];
	prod_t pb_q [3];
	logic [2:0] bias_q;
	edge_t hw_q [3];
	coord_t xlo01;
	coord_t xhi01;
	coord_t ylo01;
	coord_t yhi01;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_BOX;
				end
			end
			ST_BOX: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_FEED;
			end
			ST_FEED: begin
				if (en && (yrow_q == ymax_q)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		feed = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_FEED: begin
				feed = 1'b1;
			end
			ST_BOX, ST_MUL, ST_SUM, ST_DRAIN: begin
				s_tready = 1'b0;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign xlo01 = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
	assign xhi01 = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
	assign ylo01 = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
	assign yhi01 = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q[0] <= clamp_coord(tri_in.x0);
			vy_q[0] <= clamp_coord(tri_in.y0);
			vx_q[1] <= clamp_coord(tri_in.x1);
			vy_q[1] <= clamp_coord(tri_in.y1);
			vx_q[2] <= clamp_coord(tri_in.x2);
			vy_q[2] <= clamp_coord(tri_in.y2);
			color_q <= tri_in.color;
		end
		if (state_q == ST_BOX) begin
			xmin_q <= (xlo01 < vx_q[2]) ? xlo01 : vx_q[2];
			xmax_q <= (xhi01 > vx_q[2]) ? xhi01 : vx_q[2];
			ymin_q <= (ylo01 < vy_q[2]) ? ylo01 : vy_q[2];
			ymax_q <= (yhi01 > vy_q[2]) ? yhi01 : vy_q[2];
		end
		if (state_q == ST_SUM) begin
			yrow_q <= ymin_q;
		end else if (feed && en) begin
			yrow_q <= yrow_q + COORD_W'(1);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_edge
		localparam int A = (g + 1) % 3;
		localparam int B = (g + 2) % 3;
		delta_t off_y;
		delta_t off_x;
		logic c_pos;

		assign off_y = {1'b0, ymin_q} - {1'b0, vy_q[A]};
		assign off_x = {1'b0, xmin_q} - {1'b0, vx_q[A]};
		assign c_pos = !c_q[g][DELTA_W-1] && (c_q[g] != '0);

		always_ff @(posedge clk) begin
			if (state_q == ST_BOX) begin
				c_q[g] <= {1'b0, vy_q[A]} - {1'b0, vy_q[B]};
				r_q[g] <= {1'b0, vx_q[B]} - {1'b0, vx_q[A]};
			end
			if (state_q == ST_MUL) begin
				pa_q[g] <= smul(r_q[g], off_y);
				pb_q[g] <= smul(c_q[g], off_x);
				// left edge, or horizontal top edge
				bias_q[g] <= c_pos || ((c_q[g] == '0) && !r_q[g][DELTA_W-1] && (r_q[g] != '0));
			end
			if (state_q == ST_SUM) begin
				hw_q[g] <= sext_prod(pa_q[g]) + sext_prod(pb_q[g]) - EDGE_W'(bias_q[g]);
			end else if (feed && en) begin
				hw_q[g] <= hw_q[g] + sext_delta(r_q[g]);
			end
		end
	end

	assign head.valid = feed;
	assign head.last = (yrow_q == ymax_q);
	assign head.row = yrow_q;
	assign head.w0 = hw_q[0];
	assign head.w1 = hw_q[1];
	assign head.w2 = hw_q[2];
	assign head.mask = '0;

	assign tri_info.xmin = xmin_q;
	assign tri_info.span_w = xmax_q - xmin_q;
	assign tri_info.c0 = sext_delta(c_q[0]);
	assign tri_info.c1 = sext_delta(c_q[1]);
	assign tri_info.c2 = sext_delta(c_q[2]);
	assign tri_info.color = color_q;

	a_feed_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEED) |-> ((yrow_q >= ymin_q) && (yrow_q <= ymax_q)))
		else $error("row outside bounding box");

	a_feed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FEED) && en && (yrow_q == ymax_q)) |=> (state_q == ST_DRAIN))
		else $error("feed did not stop after bottom row");

endmodule
`default_nettype wire

// ===== src/triangle_edge_function_rasterizer.sv =====
`default_nettype none
// rows cross the TILE_SIZE-cell column chain and leave one row per cycle,
// unless m_tready stalls the chain
// one triangle at a time: the next is taken after its last row is delivered
// reset clears the sequencer, the cell valid bits and the output valid
module triangle_edge_function_rasterizer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, fill_color
	input  wire logic [terfr_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// row_y, span_left, coverage, pixel_color
	output logic [terfr_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast
);
	import terfr_pkg::*;

	tri_in_t tri_in;
	tri_t tri_info;
	link_t chain [TILE_SIZE+1];
	logic [TILE_SIZE-1:0] cell_valid;
	logic en;
	logic done;
	logic out_valid_q;
	coord_t row_q;
	coord_t left_q;
	logic [COV_W-1:0] cov_q;
	logic [COLOR_W-1:0] color_q;
	logic last_q;
	link_t tail;

	assign tri_in.x0 = s_tdata[COORD_W-1:0];
	assign tri_in.y0 = s_tdata[2*COORD_W-1:COORD_W];
	assign tri_in.x1 = s_tdata[3*COORD_W-1:2*COORD_W];
	assign tri_in.y1 = s_tdata[4*COORD_W-1:3*COORD_W];
	assign tri_in.x2 = s_tdata[5*COORD_W-1:4*COORD_W];
	assign tri_in.y2 = s_tdata[6*COORD_W-1:5*COORD_W];
	assign tri_in.color = s_tdata[S_FIELDS_W-1:6*COORD_W];

	assign en = !out_valid_q || m_tready;
	assign done = out_valid_q && m_tready && last_q;

	terfr_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.tri_in   (tri_in),
		.en       (en),
		.done     (done),
		.head     (chain[0]),
		.tri_info (tri_info)
	);

	for (genvar g = 0; g < TILE_SIZE; g++) begin : g_cell
		terfr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.idx      (COORD_W'(g)),
			.tri_info (tri_info),
			.link_in  (chain[g]),
			.link_out (chain[g+1])
		);
		assign cell_valid[g] = chain[g+1].valid;
	end

	assign tail = chain[TILE_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tail.valid) begin
			row_q <= tail.row;
			left_q <= tri_info.xmin;
			cov_q <= tail.mask;
			color_q <= tri_info.color;
			last_q <= tail.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = last_q;
	assign m_tdata = {{M_PAD_W{1'b0}}, color_q, cov_q, left_q, row_q};

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cell_valid == '0))
		else $error("triangle taken while rows still in the chain");

	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && tail.valid) |=> tail.valid)
		else $error("row dropped from the chain during a stall");

endmodule
`default_nettype wire
